[src/assert_macros.svh]
// Assertion macros used by the top level of the pulse capture framer.
// Needs nothing else; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RCPC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcpc assertion failed");
`define RCPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcpc assertion failed");
`else
`define RCPC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RCPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[src/rcpc_pkg.sv]
// Shared types and constants of the RC pulse capture framer.
// Used by rcpc_chan_mem and rc_pulse_capture_framer_unit; depends on nothing.
package rcpc_pkg;

   localparam int NUM_CHANNELS_DEF = 9;
   localparam int TIME_BITS_DEF    = 16;

   localparam int CHAN_BITS     = 4;
   localparam int STAMP_BITS    = 16;
   localparam int WIDTH_BITS    = 15;
   localparam int MASK_BITS     = 8;
   localparam int TICK_BITS     = 16;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CHAN_BITS-1:0] LAST_FOUND_CH = 4'd8;

   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WIDTH     = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_WIDTH     = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REQUIRED_MASK = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAME_TIMEOUT = 4'd3;

   localparam logic [WIDTH_BITS-1:0] MIN_WIDTH_RST     = 15'd900;
   localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RST     = 15'd2100;
   localparam logic [MASK_BITS-1:0]  REQUIRED_MASK_RST = 8'hFF;
   localparam logic [TICK_BITS-1:0]  FRAME_TIMEOUT_RST = 16'd10;

   typedef struct packed {
      logic rise_wr;
      logic rise_rd;
      logic width_wr;
      logic width_rd;
   } mem_ctl_type;

endpackage

[src/rcpc_chan_mem.sv]
// Per-channel rise time and pulse width memories with registered reads.
// Valid bits make unwritten entries read as zero. Depends on rcpc_pkg.
module rcpc_chan_mem #(
   parameter int NUM_CHANNELS = rcpc_pkg::NUM_CHANNELS_DEF,
   parameter int TIME_BITS    = rcpc_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rcpc_pkg::mem_ctl_type               ctl,
   input  logic [$clog2(NUM_CHANNELS)-1:0]     addr,
   input  logic [TIME_BITS-1:0]                rise_wdata,
   input  logic [rcpc_pkg::WIDTH_BITS-1:0]     width_wdata,
   output logic [TIME_BITS-1:0]                rise_rdata,
   output logic [rcpc_pkg::WIDTH_BITS-1:0]     width_rdata
);

   logic [TIME_BITS-1:0]            rise_mem [NUM_CHANNELS];
   logic [rcpc_pkg::WIDTH_BITS-1:0] width_mem [NUM_CHANNELS];

   logic [NUM_CHANNELS-1:0]         rise_vld_ff;
   logic [NUM_CHANNELS-1:0]         width_vld_ff;
   logic [TIME_BITS-1:0]            rise_q_ff;
   logic [rcpc_pkg::WIDTH_BITS-1:0] width_q_ff;
   logic                            rise_hit_ff;
   logic                            width_hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.rise_wr) begin
         rise_mem[addr] <= rise_wdata;
      end
      if (ctl.width_wr) begin
         width_mem[addr] <= width_wdata;
      end
      if (ctl.rise_rd) begin
         rise_q_ff <= rise_mem[addr];
      end
      if (ctl.width_rd) begin
         width_q_ff <= width_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_vld_ff  <= '0;
         width_vld_ff <= '0;
         rise_hit_ff  <= 1'b0;
         width_hit_ff <= 1'b0;
      end else begin
         if (ctl.rise_wr) begin
            rise_vld_ff[addr] <= 1'b1;
         end
         if (ctl.width_wr) begin
            width_vld_ff[addr] <= 1'b1;
         end
         if (ctl.rise_rd) begin
            rise_hit_ff <= rise_vld_ff[addr];
         end
         if (ctl.width_rd) begin
            width_hit_ff <= width_vld_ff[addr];
         end
      end
   end

   assign rise_rdata  = rise_hit_ff  ? rise_q_ff  : '0;
   assign width_rdata = width_hit_ff ? width_q_ff : '0;

endmodule

[src/rc_pulse_capture_framer_unit.sv]
// Top level of the RC pulse capture framer: edge capture, framing and reports.
// Depends on rcpc_pkg, rcpc_chan_mem and assert_macros.svh.
// Falling edge: memory read, then ST_EDGE update; rising edge or quiet tick applies directly.
// Report: per channel, width memory read (ST_RPT_RD), then output load (ST_RPT_OUT) once the output is free.
// Throughput: one transaction at a time; input stalls until the current one finishes.
// Reset: synchronous, clears control state, config to defaults, stored values read as zero.
`include "assert_macros.svh"

module rc_pulse_capture_framer_unit #(
   parameter int NUM_CHANNELS = rcpc_pkg::NUM_CHANNELS_DEF,
   parameter int TIME_BITS    = rcpc_pkg::TIME_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [rcpc_pkg::CHAN_BITS-1:0]       req_channel,
   input  logic                                 req_level,
   input  logic [rcpc_pkg::STAMP_BITS-1:0]      req_timestamp,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rcpc_pkg::CHAN_BITS-1:0]       rsp_report_channel,
   output logic [rcpc_pkg::WIDTH_BITS-1:0]      rsp_width,
   output logic                                 rsp_rx_ok,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rcpc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rcpc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int IDX_W  = $clog2(NUM_CHANNELS);
   localparam int HALF_W = TIME_BITS - 1;
   localparam int CMP_W  = (HALF_W > rcpc_pkg::WIDTH_BITS) ? HALF_W : rcpc_pkg::WIDTH_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
   localparam logic [rcpc_pkg::CHAN_BITS:0] CH_LIMIT = (rcpc_pkg::CHAN_BITS + 1)'(NUM_CHANNELS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EDGE,
      ST_RPT_RD,
      ST_RPT_OUT
   } state_type;

   state_type                         state_ff, state_in;
   logic [IDX_W-1:0]                  addr_ff, addr_in;
   logic [rcpc_pkg::CHAN_BITS-1:0]    chan_ff, chan_in;
   logic [TIME_BITS-1:0]              stamp_ff, stamp_in;
   logic [rcpc_pkg::MASK_BITS-1:0]    found_ff, found_in;
   logic                              done_ff, done_in;
   logic [rcpc_pkg::TICK_BITS-1:0]    last_tick_ff, last_tick_in;
   logic [rcpc_pkg::TICK_BITS-1:0]    beat_ff, beat_in;
   logic                              ok_ff, ok_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rcpc_pkg::CHAN_BITS-1:0]    rsp_chan_ff, rsp_chan_in;
   logic [rcpc_pkg::WIDTH_BITS-1:0]   rsp_width_ff, rsp_width_in;
   logic                              rsp_ok_ff, rsp_ok_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic [rcpc_pkg::WIDTH_BITS-1:0]   min_width_ff, min_width_in;
   logic [rcpc_pkg::WIDTH_BITS-1:0]   max_width_ff, max_width_in;
   logic [rcpc_pkg::MASK_BITS-1:0]    req_mask_ff, req_mask_in;
   logic [rcpc_pkg::TICK_BITS-1:0]    timeout_ff, timeout_in;

   logic                              req_fire;
   logic                              rsp_free;
   logic [rcpc_pkg::CHAN_BITS-1:0]    ch_m1;
   logic [rcpc_pkg::CHAN_BITS-1:0]    chan_ff_m1;
   logic                              ch_ok;
   logic                              is_edge;
   logic [rcpc_pkg::TICK_BITS-1:0]    beat_next;
   logic [rcpc_pkg::TICK_BITS-1:0]    elapsed;
   logic                              timed_out;
   logic [TIME_BITS-1:0]              rise_rdata;
   logic [rcpc_pkg::WIDTH_BITS-1:0]   width_rdata;
   logic [TIME_BITS-1:0]              diff;
   logic [CMP_W-1:0]                  half_cmp;
   logic                              in_range;
   logic [rcpc_pkg::MASK_BITS-1:0]    found_new;
   rcpc_pkg::mem_ctl_type             mem_ctl;
   logic [IDX_W-1:0]                  mem_addr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign ch_m1      = req_channel - 4'd1;
   assign chan_ff_m1 = chan_ff - 4'd1;
   assign ch_ok      = (req_channel != '0) && ({1'b0, req_channel} <= CH_LIMIT);
   assign is_edge    = (req_command == rcpc_pkg::CMD_EDGE);

   assign beat_next = beat_ff + 16'd1;
   assign elapsed   = beat_next - last_tick_ff;
   assign timed_out = (elapsed >= timeout_ff);

   assign diff     = stamp_ff - rise_rdata;
   assign half_cmp = CMP_W'(diff[TIME_BITS-1:1]);
   assign in_range = (half_cmp <= CMP_W'(max_width_ff)) && (half_cmp >= CMP_W'(min_width_ff));
   assign found_new = found_ff |
      ((chan_ff <= rcpc_pkg::LAST_FOUND_CH) ? (8'd1 << chan_ff_m1[2:0]) : 8'd0);

   assign mem_ctl.rise_wr  = req_fire && is_edge && ch_ok && req_level;
   assign mem_ctl.rise_rd  = req_fire && is_edge && ch_ok && !req_level;
   assign mem_ctl.width_wr = (state_ff == ST_EDGE) && in_range;
   assign mem_ctl.width_rd = (state_ff == ST_RPT_RD);
   assign mem_addr = (state_ff == ST_IDLE) ? ch_m1[IDX_W-1:0] : addr_ff;

   rcpc_chan_mem #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .TIME_BITS    (TIME_BITS)
   ) u_chan_mem (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mem_ctl),
      .addr        (mem_addr),
      .rise_wdata  (TIME_BITS'(req_timestamp)),
      .width_wdata (rcpc_pkg::WIDTH_BITS'(diff[TIME_BITS-1:1])),
      .rise_rdata  (rise_rdata),
      .width_rdata (width_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      chan_in      = chan_ff;
      stamp_in     = stamp_ff;
      found_in     = found_ff;
      done_in      = done_ff;
      last_tick_in = last_tick_ff;
      beat_in      = beat_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_width_in = rsp_width_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      min_width_in = min_width_ff;
      max_width_in = max_width_ff;
      req_mask_in  = req_mask_ff;
      timeout_in   = timeout_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_edge) begin
                  if (ch_ok && !req_level) begin
                     addr_in  = ch_m1[IDX_W-1:0];
                     chan_in  = req_channel;
                     stamp_in = TIME_BITS'(req_timestamp);
                     state_in = ST_EDGE;
                  end
               end else begin
                  beat_in = beat_next;
                  if (done_ff || (timed_out && (found_ff != '0))) begin
                     found_in = '0;
                     done_in  = 1'b0;
                     ok_in    = done_ff;
                     addr_in  = '0;
                     state_in = ST_RPT_RD;
                  end
               end
            end
         end
         ST_EDGE: begin
            if (in_range) begin
               last_tick_in = beat_ff;
               found_in     = found_new;
               if ((found_new & req_mask_ff) == req_mask_ff) begin
                  done_in = 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         ST_RPT_RD: begin
            state_in = ST_RPT_OUT;
         end
         ST_RPT_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = rcpc_pkg::CHAN_BITS'(addr_ff) + 4'd1;
               rsp_width_in = width_rdata;
               rsp_ok_in    = ok_ff;
               rsp_last_in  = (addr_ff == LAST_IDX);
               if (addr_ff == LAST_IDX) begin
                  state_in = ST_IDLE;
               end else begin
                  addr_in  = addr_ff + 1'b1;
                  state_in = ST_RPT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            rcpc_pkg::CSR_MIN_WIDTH:     min_width_in = csr_wdata[rcpc_pkg::WIDTH_BITS-1:0];
            rcpc_pkg::CSR_MAX_WIDTH:     max_width_in = csr_wdata[rcpc_pkg::WIDTH_BITS-1:0];
            rcpc_pkg::CSR_REQUIRED_MASK: req_mask_in  = csr_wdata[rcpc_pkg::MASK_BITS-1:0];
            rcpc_pkg::CSR_FRAME_TIMEOUT: timeout_in   = csr_wdata[rcpc_pkg::TICK_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         found_ff     <= '0;
         done_ff      <= 1'b0;
         last_tick_ff <= '0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         min_width_ff <= rcpc_pkg::MIN_WIDTH_RST;
         max_width_ff <= rcpc_pkg::MAX_WIDTH_RST;
         req_mask_ff  <= rcpc_pkg::REQUIRED_MASK_RST;
         timeout_ff   <= rcpc_pkg::FRAME_TIMEOUT_RST;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         done_ff      <= done_in;
         last_tick_ff <= last_tick_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
         min_width_ff <= min_width_in;
         max_width_ff <= max_width_in;
         req_mask_ff  <= req_mask_in;
         timeout_ff   <= timeout_in;
         addr_ff      <= addr_in;
         chan_ff      <= chan_in;
         stamp_ff     <= stamp_in;
         ok_ff        <= ok_in;
         rsp_chan_ff  <= rsp_chan_in;
         rsp_width_ff <= rsp_width_in;
         rsp_ok_ff    <= rsp_ok_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_report_channel = rsp_chan_ff;
   assign rsp_width          = rsp_width_ff;
   assign rsp_rx_ok          = rsp_ok_ff;
   assign rsp_last           = rsp_last_ff;

   `RCPC_ASSERT_NEXT(a_edge_one_cycle, clock, reset, state_ff == ST_EDGE, state_ff == ST_IDLE)
   `RCPC_ASSERT_IMPL(a_report_cleared, clock, reset, state_ff == ST_RPT_RD || state_ff == ST_RPT_OUT, found_ff == '0 && !done_ff)
   `RCPC_ASSERT_IMPL(a_last_channel, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_chan_ff == rcpc_pkg::CHAN_BITS'(NUM_CHANNELS))
   `RCPC_ASSERT_NEXT(a_tick_report, clock, reset, req_fire && !is_edge && done_ff, state_ff == ST_RPT_RD && ok_ff)

endmodule
